>>> src/iwn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO week number package
// Widths, month codes, inter-stage words and small helper functions shared by
// the stages of the ISO 8601 week number pipeline.
// ----------------------------------------------------------------------------
package iwn_pkg;

  // Field widths of the input and result words.
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WEEK_W  = 6;

  // Internal widths.
  localparam int unsigned Q25_W = 10;  // year / 25 for a 14-bit year
  localparam int unsigned ORD_W = 9;   // day of year, up to 366 plus slack
  localparam int unsigned WD_W  = 3;   // weekday 0..6

  // Reciprocal of 25 for a 14-bit dividend: floor(x * 5243 / 2^17).
  localparam int unsigned RCP25_MUL = 5243;
  localparam int unsigned RCP25_SH  = 17;
  localparam int unsigned RCP25_PW  = YEAR_W + 13;

  // Reciprocal of 7 for a dividend below 512: floor(x * 293 / 2^11).
  localparam int unsigned RCP7_MUL = 293;
  localparam int unsigned RCP7_SH  = 11;
  localparam int unsigned RCP7_PW  = 18;

  // Month codes that the logic looks at.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  // Weekday codes of January 1 (0 is Monday) that give a 53-week year.
  localparam logic [WD_W-1:0] WD_WED = 3'd2;
  localparam logic [WD_W-1:0] WD_THU = 3'd3;

  localparam logic [WEEK_W-1:0] WEEK_ONE  = 6'd1;
  localparam logic [WEEK_W-1:0] WEEK_LAST = 6'd53;
  localparam logic [WEEK_W-1:0] WEEK_52   = 6'd52;

  // Word between the divide stage and the calendar stage.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  prev;
    logic [Q25_W-1:0]   q25_year;
    logic [Q25_W-1:0]   q25_prev;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } div_word_t;

  // Word between the calendar stage and the week stage.
  typedef struct packed {
    logic [WD_W-1:0]  jan1;
    logic [WD_W-1:0]  ord_mod7;
    logic [ORD_W-1:0] ordinal;
    logic             leap_year;
    logic             leap_prev;
  } cal_word_t;

  // Days before the first of each month in a common year.
  function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

  // Remainder modulo 7 of a 15-bit value: 8 is 1 mod 7, so octal digits add.
  function automatic logic [WD_W-1:0] mod7(input logic [14:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

>>> src/iwn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO week number: divide stage
// Forms the previous year and divides both years by 25 through a constant
// reciprocal multiply, then registers the word for the calendar stage.
// ----------------------------------------------------------------------------
module iwn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [iwn_pkg::YEAR_W-1:0]  year,
  input  logic [iwn_pkg::MONTH_W-1:0] month,
  input  logic [iwn_pkg::DAY_W-1:0]   day,
  output logic                        out_vld,
  output iwn_pkg::div_word_t          out_word
);

  logic [iwn_pkg::YEAR_W-1:0]    prev;
  logic [iwn_pkg::RCP25_PW-1:0]  prod_year;
  logic [iwn_pkg::RCP25_PW-1:0]  prod_prev;
  iwn_pkg::div_word_t            word_nxt;
  iwn_pkg::div_word_t            word_r;
  logic                          vld_r;

  // Year is at least one here, so the previous year never wraps.
  assign prev = year - iwn_pkg::YEAR_W'(1);

  // Exact floor division by 25 for any 14-bit value.
  assign prod_year = iwn_pkg::RCP25_PW'(year) * iwn_pkg::RCP25_PW'(iwn_pkg::RCP25_MUL);
  assign prod_prev = iwn_pkg::RCP25_PW'(prev) * iwn_pkg::RCP25_PW'(iwn_pkg::RCP25_MUL);

  always_comb begin
    word_nxt.year     = year;
    word_nxt.prev     = prev;
    word_nxt.q25_year = prod_year[iwn_pkg::RCP25_SH +: iwn_pkg::Q25_W];
    word_nxt.q25_prev = prod_prev[iwn_pkg::RCP25_SH +: iwn_pkg::Q25_W];
    word_nxt.month    = month;
    word_nxt.day      = day;
  end

  // Stage register: valid is reset, payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

>>> src/iwn_cal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO week number: calendar stage
// Leap flags of the year and the year before, weekday of January 1 and the
// day of year, registered for the week stage.
// ----------------------------------------------------------------------------
module iwn_cal (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  iwn_pkg::div_word_t in_word,
  output logic               out_vld,
  output iwn_pkg::cal_word_t out_word
);

  logic [iwn_pkg::YEAR_W-1:0] m25_year;
  logic [iwn_pkg::YEAR_W-1:0] m25_prev;
  logic                       c100_year;
  logic                       c100_prev;
  logic                       leap_year;
  logic                       leap_prev;
  logic [14:0]                day_sum;
  logic [iwn_pkg::ORD_W-1:0]  ordinal;
  iwn_pkg::cal_word_t         word_nxt;
  iwn_pkg::cal_word_t         word_r;
  logic                       vld_r;

  // Remainder by 25 from the quotient; divisible by 100 is by 4 and by 25.
  assign m25_year  = in_word.year - iwn_pkg::YEAR_W'(in_word.q25_year * 5'd25);
  assign m25_prev  = in_word.prev - iwn_pkg::YEAR_W'(in_word.q25_prev * 5'd25);
  assign c100_year = (in_word.year[1:0] == 2'b00) && (m25_year[4:0] == 5'd0);
  assign c100_prev = (in_word.prev[1:0] == 2'b00) && (m25_prev[4:0] == 5'd0);

  // Leap: by 4 and not by 100, or by 400 (a century whose year/25 is by 16).
  assign leap_year = (in_word.year[1:0] == 2'b00) &&
                     (!c100_year || (in_word.q25_year[3:0] == 4'd0));
  assign leap_prev = (in_word.prev[1:0] == 2'b00) &&
                     (!c100_prev || (in_word.q25_prev[3:0] == 4'd0));

  // Days from year 1 to January 1, modulo 7; 365 is 1 mod 7.
  assign day_sum = 15'(in_word.prev) + 15'(in_word.prev[iwn_pkg::YEAR_W-1:2])
                 - 15'(in_word.q25_prev[iwn_pkg::Q25_W-1:2])
                 + 15'(in_word.q25_prev[iwn_pkg::Q25_W-1:4]);

  // Day of year, with the leap day after February.
  assign ordinal = iwn_pkg::days_before(in_word.month) + iwn_pkg::ORD_W'(in_word.day)
                 + iwn_pkg::ORD_W'(leap_year && (in_word.month > iwn_pkg::MONTH_FEB));

  always_comb begin
    word_nxt.jan1      = iwn_pkg::mod7(day_sum);
    word_nxt.ord_mod7  = iwn_pkg::mod7(15'(ordinal));
    word_nxt.ordinal   = ordinal;
    word_nxt.leap_year = leap_year;
    word_nxt.leap_prev = leap_prev;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

>>> src/iwn_week.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO week number: week stage
// Applies the ISO week rule, folds early January back into the previous
// year and late December forward into week 1, and holds the result register.
// ----------------------------------------------------------------------------
module iwn_week (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  iwn_pkg::cal_word_t         in_word,
  output logic                       out_vld,
  output logic [iwn_pkg::WEEK_W-1:0] out_week
);

  logic [iwn_pkg::WD_W-1:0]    wd0;
  logic [iwn_pkg::WD_W:0]      wd;
  logic [iwn_pkg::ORD_W-1:0]   num;
  logic [iwn_pkg::RCP7_PW-1:0] prod;
  logic [iwn_pkg::WEEK_W-1:0]  wk;
  logic [iwn_pkg::WD_W-1:0]    prev_jan1;
  logic                        long_year;
  logic                        long_prev;
  logic [iwn_pkg::WEEK_W-1:0]  week_nxt;
  logic [iwn_pkg::WEEK_W-1:0]  week_r;
  logic                        vld_r;

  // ISO weekday of the date, 1 is Monday.
  assign wd0 = iwn_pkg::mod7(15'(in_word.jan1) + 15'(in_word.ord_mod7) + 15'd6);
  assign wd  = {1'b0, wd0} + 4'd1;

  // Week = (ordinal + 10 - weekday) / 7, through a reciprocal multiply.
  assign num  = in_word.ordinal + 9'd10 - 9'(wd);
  assign prod = iwn_pkg::RCP7_PW'(num) * iwn_pkg::RCP7_PW'(iwn_pkg::RCP7_MUL);
  assign wk   = prod[iwn_pkg::RCP7_SH +: iwn_pkg::WEEK_W];

  // January 1 of the previous year steps back by its length modulo 7.
  assign prev_jan1 = iwn_pkg::mod7(15'(in_word.jan1) + (in_word.leap_prev ? 15'd5 : 15'd6));

  assign long_year = (in_word.jan1 == iwn_pkg::WD_THU) ||
                     (in_word.leap_year && (in_word.jan1 == iwn_pkg::WD_WED));
  assign long_prev = (prev_jan1 == iwn_pkg::WD_THU) ||
                     (in_word.leap_prev && (prev_jan1 == iwn_pkg::WD_WED));

  // Week zero belongs to the prior year; past the last week is week 1.
  always_comb begin
    priority if (wk == '0) begin
      week_nxt = long_prev ? iwn_pkg::WEEK_LAST : iwn_pkg::WEEK_52;
    end else if (wk > (long_year ? iwn_pkg::WEEK_LAST : iwn_pkg::WEEK_52)) begin
      week_nxt = iwn_pkg::WEEK_ONE;
    end else begin
      week_nxt = wk;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    week_r <= week_nxt;
  end

  assign out_vld  = vld_r;
  assign out_week = week_r;

endmodule

>>> src/iso_week_number.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO 8601 week number
// A date word (year, zero-based month, day) enters when start is high and
// busy is low; busy stays low, so a date can be given every clock cycle.
// Each date produces one result word: out_week with out_valid high for one
// cycle. The pipeline is an input register, a divide-by-25 stage, a calendar
// stage and the result register, taking one word per cycle at full rate.
// Years are clamped to 1..YEAR_MAX and months above December read as
// December; the day is not checked against the month length.
// The receiver cannot stall: a result word is shown for exactly one cycle.
// A synchronous reset (rst_n low) clears all valid flags, dropping any dates
// in flight; no results appear until new dates are started.
// ----------------------------------------------------------------------------
module iso_week_number #(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [iwn_pkg::YEAR_W-1:0]  in_year,
  input  logic [iwn_pkg::MONTH_W-1:0] in_month,
  input  logic [iwn_pkg::DAY_W-1:0]   in_day,
  output logic                        out_valid,
  output logic [iwn_pkg::WEEK_W-1:0]  out_week
);

  logic                        vld_r;
  logic [iwn_pkg::YEAR_W-1:0]  year_nxt;
  logic [iwn_pkg::YEAR_W-1:0]  year_r;
  logic [iwn_pkg::MONTH_W-1:0] month_nxt;
  logic [iwn_pkg::MONTH_W-1:0] month_r;
  logic [iwn_pkg::DAY_W-1:0]   day_r;
  logic                        div_vld;
  iwn_pkg::div_word_t          div_word;
  logic                        cal_vld;
  iwn_pkg::cal_word_t          cal_word;

  assign busy = 1'b0;

  // Clamp the year and month on the way into the input register.
  always_comb begin
    priority if (in_year == '0) begin
      year_nxt = iwn_pkg::YEAR_W'(1);
    end else if (32'(in_year) > YEAR_MAX) begin
      year_nxt = iwn_pkg::YEAR_W'(YEAR_MAX);
    end else begin
      year_nxt = in_year;
    end
    month_nxt = (in_month > iwn_pkg::MONTH_DEC) ? iwn_pkg::MONTH_DEC : in_month;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= in_day;
  end

  iwn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r),
    .year     (year_r),
    .month    (month_r),
    .day      (day_r),
    .out_vld  (div_vld),
    .out_word (div_word)
  );

  iwn_cal u_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div_vld),
    .in_word  (div_word),
    .out_vld  (cal_vld),
    .out_word (cal_word)
  );

  iwn_week u_week (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cal_vld),
    .in_word  (cal_word),
    .out_vld  (out_valid),
    .out_week (out_week)
  );

endmodule

>>> src/iwn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO week number checker
// Port-level assertions on latency, result range and repeatability, bound
// to the top level.
// ----------------------------------------------------------------------------
module iwn_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [iwn_pkg::YEAR_W-1:0]  in_year,
  input logic [iwn_pkg::MONTH_W-1:0] in_month,
  input logic [iwn_pkg::DAY_W-1:0]   in_day,
  input logic                        out_valid,
  input logic [iwn_pkg::WEEK_W-1:0]  out_week
);

  // Every accepted date gives a result word once it has passed the pipeline registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result word missing four cycles after a start");

  // No result word without a matching accepted date.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result word without a matching start");

  // A week number is always 1 to 53.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_week >= iwn_pkg::WEEK_ONE) && (out_week <= iwn_pkg::WEEK_LAST))
    else $error("week number out of range");

  // The same date given twice in a row gives the same week twice.
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) &&
     ($past(in_year, 4) == $past(in_year, 5)) &&
     ($past(in_month, 4) == $past(in_month, 5)) &&
     ($past(in_day, 4) == $past(in_day, 5))) |-> (out_week == $past(out_week)))
    else $error("same date gave different weeks");

endmodule

bind iso_week_number iwn_checker u_iwn_checker (.*);
